FILE: rtl/core/link_reconnect_backoff_controller_macros.svh
// Assertion macros for the link reconnect controller RTL.
`ifndef LINK_RECONNECT_BACKOFF_CONTROLLER_MACROS_SVH
`define LINK_RECONNECT_BACKOFF_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
`define LRBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define LRBC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define LRBC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LRBC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/lrbc_pkg.sv
// Types, codes and reset constants for the link reconnect backoff controller.
`timescale 1ns / 1ps
package lrbc_pkg;

    typedef enum logic [3:0]
    {
        MODE_DISABLED   = 4'b0001,
        MODE_CONNECTING = 4'b0010,
        MODE_CONNECTED  = 4'b0100,
        MODE_WAITING    = 4'b1000
    } mode_t;

    localparam logic [1:0] MODE_CODE_DISABLED   = 2'd0;
    localparam logic [1:0] MODE_CODE_CONNECTING = 2'd1;
    localparam logic [1:0] MODE_CODE_CONNECTED  = 2'd2;
    localparam logic [1:0] MODE_CODE_WAITING    = 2'd3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_POLL  = 1'b1;

    localparam logic [1:0] REG_CONNECT_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_BACKOFF_INITIAL = 2'd1;
    localparam logic [1:0] REG_BACKOFF_MAX     = 2'd2;

    localparam logic [30:0] CONNECT_TIMEOUT_RST = 31'd10000;
    localparam logic [30:0] BACKOFF_INITIAL_RST = 31'd1000;
    localparam logic [30:0] BACKOFF_MAX_RST     = 31'd60000;

    typedef struct packed
    {
        logic        op;
        logic [31:0] now_ms;
        logic        link_up;
        logic        has_credentials;
    } item_t;

    typedef struct packed
    {
        logic [30:0] connect_timeout_ms;
        logic [30:0] backoff_initial_ms;
        logic [30:0] backoff_max_ms;
    } cfg_t;

    typedef struct packed
    {
        mode_t       mode;
        logic [31:0] attempts;
        logic [31:0] start_time;
        logic [31:0] retry_time;
        logic [30:0] backoff;
    } state_t;

    typedef struct packed
    {
        logic [1:0]  mode;
        logic        start_attempt;
        logic        drop_link;
        logic [31:0] attempts;
        logic [30:0] retry_delay_ms;
    } result_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] c;
        unique case (m)
            MODE_DISABLED:   c = MODE_CODE_DISABLED;
            MODE_CONNECTING: c = MODE_CODE_CONNECTING;
            MODE_CONNECTED:  c = MODE_CODE_CONNECTED;
            MODE_WAITING:    c = MODE_CODE_WAITING;
            default:         c = MODE_CODE_DISABLED;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/lrbc_step.sv
// Next-state and result logic for one item of the reconnect controller.
`timescale 1ns / 1ps
module lrbc_step
(
    input  lrbc_pkg::item_t   item,
    input  lrbc_pkg::cfg_t    cfg,
    input  lrbc_pkg::state_t  cur,
    output lrbc_pkg::state_t  nxt,
    output lrbc_pkg::result_t res
);
    import lrbc_pkg::*;

    logic [31:0] timeout_deadline;
    logic [31:0] timeout_diff;
    logic [31:0] retry_diff;
    logic        timeout_reached;
    logic        retry_reached;
    logic [30:0] backoff_doubled;
    logic [30:0] backoff_capped;

    // Deadlines use the sign of the wrapped difference, so they survive timestamp wrap.
    assign timeout_deadline = cur.start_time + {1'b0, cfg.connect_timeout_ms};
    assign timeout_diff     = item.now_ms - timeout_deadline;
    assign retry_diff       = item.now_ms - cur.retry_time;
    assign timeout_reached  = ~timeout_diff[31];
    assign retry_reached    = ~retry_diff[31];

    assign backoff_doubled = {cur.backoff[29:0], 1'b0};
    assign backoff_capped  = (cur.backoff >= (cfg.backoff_max_ms >> 1)) ?
                             cfg.backoff_max_ms : backoff_doubled;

    always_comb
    begin
        logic begin_att;
        begin_att          = 1'b0;
        nxt                = cur;
        res.start_attempt  = 1'b0;
        res.drop_link      = 1'b0;
        res.retry_delay_ms = '0;

        if (item.op == OP_START)
        begin
            if (!item.has_credentials)
            begin
                nxt.mode = MODE_DISABLED;
            end
            else
            begin
                nxt.backoff = cfg.backoff_initial_ms;
                begin_att   = 1'b1;
            end
        end
        else
        begin
            unique case (cur.mode)
                MODE_CONNECTING:
                begin
                    if (item.link_up)
                    begin
                        nxt.mode    = MODE_CONNECTED;
                        nxt.backoff = cfg.backoff_initial_ms;
                    end
                    else if (timeout_reached)
                    begin
                        res.drop_link      = 1'b1;
                        nxt.retry_time     = item.now_ms + {1'b0, cur.backoff};
                        nxt.mode           = MODE_WAITING;
                        res.retry_delay_ms = cur.backoff;
                        nxt.backoff        = backoff_capped;
                    end
                end
                MODE_CONNECTED:
                begin
                    if (!item.link_up)
                    begin
                        res.drop_link = 1'b1;
                        nxt.backoff   = cfg.backoff_initial_ms;
                        begin_att     = 1'b1;
                    end
                end
                MODE_WAITING:
                begin
                    if (retry_reached)
                    begin
                        begin_att = 1'b1;
                    end
                end
                MODE_DISABLED:
                begin
                end
                default:
                begin
                end
            endcase
        end

        if (begin_att)
        begin
            nxt.attempts      = cur.attempts + 32'd1;
            nxt.start_time    = item.now_ms;
            nxt.mode          = MODE_CONNECTING;
            res.start_attempt = 1'b1;
        end

        res.mode     = mode_code(nxt.mode);
        res.attempts = nxt.attempts;
    end

endmodule

FILE: rtl/core/link_reconnect_backoff_controller.sv
// Top level of the link reconnect controller with capped exponential backoff.
//
// Items arrive on the s_ channel: a start command or a poll (s_tuser) with a
// millisecond timestamp and the link flags in s_tdata. Each accepted item gives
// exactly one result item on the m_ channel: the mode after the step, the
// start-attempt and drop-link pulses, the attempt count and the retry delay.
// The item is held in an input register; the state update and the result are
// computed from it combinationally and land in the result register, which
// drives m_tvalid; a stalled receiver keeps the item in the input register.
// One item is taken per cycle for as long as the receiver keeps m_tready high;
// the combinational state update is what makes that possible.
// When the receiver stalls, the result register holds and one further item
// waits in the input register, after which s_tready drops.
// Configuration goes in through cfg_we, cfg_addr and cfg_wdata; the user must write
// it only while the block is idle (not enforced by the block); index 3 is ignored.
// Reset empties both registers, puts the mode to disabled, the counter and
// times to zero, the backoff to 1000 ms and the registers to their defaults.
`timescale 1ns / 1ps
`include "link_reconnect_backoff_controller_macros.svh"
module link_reconnect_backoff_controller
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [30:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: now_ms[31:0], link_up[32], has_credentials[33], zero fill[39:34]
    input  logic [39:0] s_tdata,
    // s_tuser: op (0 start, 1 poll)
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: mode[1:0], start_attempt[2], drop_link[3], attempts[35:4],
    // retry_delay_ms[66:36], zero fill[71:67]
    output logic [71:0] m_tdata
);
    import lrbc_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    cfg_t    cfg_reg;
    item_t   s_item;
    logic    load;

    assign s_item.op              = s_tuser;
    assign s_item.now_ms          = s_tdata[31:0];
    assign s_item.link_up         = s_tdata[32];
    assign s_item.has_credentials = s_tdata[33];

    // The held item moves on whenever the result register is free or being drained.
    assign load     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || load;

    lrbc_step u_step
    (
        .item (in_item_reg),
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode       <= MODE_DISABLED;
            state_reg.attempts   <= '0;
            state_reg.start_time <= '0;
            state_reg.retry_time <= '0;
            state_reg.backoff    <= BACKOFF_INITIAL_RST;
        end
        else if (load)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.connect_timeout_ms <= CONNECT_TIMEOUT_RST;
            cfg_reg.backoff_initial_ms <= BACKOFF_INITIAL_RST;
            cfg_reg.backoff_max_ms     <= BACKOFF_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CONNECT_TIMEOUT: cfg_reg.connect_timeout_ms <= cfg_wdata;
                REG_BACKOFF_INITIAL: cfg_reg.backoff_initial_ms <= cfg_wdata;
                REG_BACKOFF_MAX:     cfg_reg.backoff_max_ms     <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_res_reg.retry_delay_ms, out_res_reg.attempts,
                       out_res_reg.drop_link, out_res_reg.start_attempt, out_res_reg.mode};

    `LRBC_ASSERT_IMP(a_start_means_connecting, clk, rst_n,
        m_tvalid && out_res_reg.start_attempt, out_res_reg.mode == MODE_CODE_CONNECTING)
    `LRBC_ASSERT_IMP(a_delay_means_waiting, clk, rst_n,
        m_tvalid && (out_res_reg.retry_delay_ms != '0), out_res_reg.mode == MODE_CODE_WAITING)
    `LRBC_ASSERT_NXT(a_load_shows_result, clk, rst_n, load, m_tvalid)
    `LRBC_ASSERT_IMP(a_empty_input_ready, clk, rst_n, !in_valid_reg, s_tready)

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the link reconnect controller with capped backoff.
`timescale 1ns / 1ps
module tb;
    import lrbc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    // Predicts one result item per accepted input item and checks the results in order.
    class reconnect_scoreboard;
        logic [30:0] timeout_ms = CONNECT_TIMEOUT_RST;
        logic [30:0] initial_ms = BACKOFF_INITIAL_RST;
        logic [30:0] cap_ms     = BACKOFF_MAX_RST;
        logic [1:0]  mode_code  = MODE_CODE_DISABLED;
        logic [31:0] attempt_count = '0;
        logic [31:0] attempt_began = '0;
        logic [31:0] retry_at      = '0;
        logic [30:0] backoff_ms    = BACKOFF_INITIAL_RST;
        result_t     expected_results[$];
        int          errors = 0;

        function void write_reg(logic [1:0] idx, logic [30:0] val);
            case (idx)
                REG_CONNECT_TIMEOUT: timeout_ms = val;
                REG_BACKOFF_INITIAL: initial_ms = val;
                REG_BACKOFF_MAX:     cap_ms = val;
                default: ;
            endcase
        endfunction

        function bit deadline_reached(logic [31:0] now, logic [31:0] deadline);
            logic [31:0] diff;
            diff = now - deadline;
            return !diff[31];
        endfunction

        function void open_attempt(logic [31:0] now, ref result_t r);
            attempt_count = attempt_count + 32'd1;
            attempt_began = now;
            mode_code = MODE_CODE_CONNECTING;
            r.start_attempt = 1'b1;
        endfunction

        function void note_item(logic op, logic [31:0] now, logic up, logic cred);
            result_t r;
            r = '0;
            if (op == OP_START)
            begin
                if (!cred)
                    mode_code = MODE_CODE_DISABLED;
                else
                begin
                    backoff_ms = initial_ms;
                    open_attempt(now, r);
                end
            end
            else
            begin
                case (mode_code)
                    MODE_CODE_CONNECTING:
                        if (up)
                        begin
                            mode_code = MODE_CODE_CONNECTED;
                            backoff_ms = initial_ms;
                        end
                        else if (deadline_reached(now, attempt_began + {1'b0, timeout_ms}))
                        begin
                            r.drop_link = 1'b1;
                            retry_at = now + {1'b0, backoff_ms};
                            mode_code = MODE_CODE_WAITING;
                            r.retry_delay_ms = backoff_ms;
                            if (backoff_ms >= (cap_ms >> 1))
                                backoff_ms = cap_ms;
                            else
                                backoff_ms = backoff_ms << 1;
                        end
                    MODE_CODE_CONNECTED:
                        if (!up)
                        begin
                            r.drop_link = 1'b1;
                            backoff_ms = initial_ms;
                            open_attempt(now, r);
                        end
                    MODE_CODE_WAITING:
                        if (deadline_reached(now, retry_at))
                            open_attempt(now, r);
                    default: ;
                endcase
            end
            r.mode = mode_code;
            r.attempts = attempt_count;
            expected_results.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [71:0] data);
            result_t e;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result item, expected none, actual %h", $time, data);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            check_field("mode", {30'd0, e.mode}, {30'd0, data[1:0]});
            check_field("start_attempt", {31'd0, e.start_attempt}, {31'd0, data[2]});
            check_field("drop_link", {31'd0, e.drop_link}, {31'd0, data[3]});
            check_field("attempts", e.attempts, data[35:4]);
            check_field("retry_delay_ms", {1'b0, e.retry_delay_ms}, {1'b0, data[66:36]});
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [30:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    reconnect_scoreboard sb;
    logic [31:0] clock_ms;
    bit          tx_no_idle;
    bit          rx_no_stall;
    int          rx_hold;
    int          quiet_cycles;

    link_reconnect_backoff_controller dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(99, 0) < 85)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else if (rx_no_stall || $urandom_range(99, 0) < 75)
            m_tready <= 1'b1;
        else
        begin
            rx_hold = gap_len() - 1;
            m_tready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_item(s_tuser, s_tdata[31:0], s_tdata[32], s_tdata[33]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("link_reconnect_backoff_controller test failed");
                $finish;
            end
        end
    end

    task automatic wait_slot();
        int gap;
        gap = (tx_no_idle || $urandom_range(99, 0) < 60) ? 0 : gap_len();
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
    endtask

    task automatic present_item(logic op, logic [31:0] now, logic up, logic cred);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, cred, up, now};
        clock_ms = now;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_item(logic op, logic [31:0] now, logic up, logic cred);
        wait_slot();
        present_item(op, now, up, cred);
    endtask

    // Lets the pipeline drain so that registers are only written while idle.
    task automatic quiesce();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [30:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic configure(logic [30:0] timeout, logic [30:0] init, logic [30:0] cap);
        quiesce();
        set_reg(REG_CONNECT_TIMEOUT, timeout);
        set_reg(REG_BACKOFF_INITIAL, init);
        set_reg(REG_BACKOFF_MAX, cap);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Time steps are scaled to the largest programmed interval so that deadlines are hit.
    function automatic logic [31:0] next_time();
        longint biggest;
        logic [31:0] span;
        int pick;
        biggest = longint'(sb.timeout_ms);
        if (longint'(sb.cap_ms) > biggest)
            biggest = longint'(sb.cap_ms);
        if (longint'(sb.initial_ms) > biggest)
            biggest = longint'(sb.initial_ms);
        span = 32'(biggest / 3 + 2);
        pick = $urandom_range(99, 0);
        if (pick < 70)
            return clock_ms + $urandom_range(span, 0);
        if (pick < 80)
            return clock_ms + $urandom_range(3, 0);
        if (pick < 90)
            return clock_ms + span + $urandom_range(span, 0);
        if (pick < 95)
            return clock_ms - $urandom_range(span, 0);
        return $urandom;
    endfunction

    // Mostly well-formed traffic: starts while disabled, polls otherwise, with a
    // link flag that tends to follow the predicted state.
    task automatic run_traffic(int count);
        logic op;
        logic up;
        logic cred;
        logic [31:0] now;
        int pick;
        for (int i = 0; i < count; i++)
        begin
            wait_slot();
            now = next_time();
            pick = $urandom_range(99, 0);
            cred = 1'($urandom_range(1, 0));
            up = 1'($urandom_range(1, 0));
            if (pick < 5)
                op = 1'($urandom_range(1, 0));
            else if ((sb.mode_code == MODE_CODE_DISABLED && pick < 85) || pick < 9)
            begin
                op = OP_START;
                cred = $urandom_range(9, 0) != 0;
            end
            else
            begin
                op = OP_POLL;
                if (sb.mode_code == MODE_CODE_CONNECTING)
                    up = $urandom_range(3, 0) == 0;
                else if (sb.mode_code == MODE_CODE_CONNECTED)
                    up = $urandom_range(4, 0) != 0;
            end
            present_item(op, now, up, cred);
        end
    endtask

    initial
    begin
        sb = new;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_POLL;
        m_tready = 1'b0;
        rx_hold = 0;
        quiet_cycles = 0;
        clock_ms = '0;
        tx_no_idle = 1'b0;
        rx_no_stall = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part on the reset configuration.
        send_item(OP_POLL,  32'd0,     1'b1, 1'b1);
        send_item(OP_START, 32'd10,    1'b1, 1'b0);
        send_item(OP_START, 32'd100,   1'b1, 1'b1);
        send_item(OP_POLL,  32'd5000,  1'b0, 1'b0);
        send_item(OP_POLL,  32'd10100, 1'b0, 1'b0);
        send_item(OP_POLL,  32'd11099, 1'b0, 1'b1);
        send_item(OP_POLL,  32'd11100, 1'b0, 1'b0);
        send_item(OP_POLL,  32'd11200, 1'b1, 1'b1);
        send_item(OP_POLL,  32'd11300, 1'b1, 1'b0);
        send_item(OP_POLL,  32'd11400, 1'b0, 1'b0);
        send_item(OP_START, 32'd11500, 1'b0, 1'b1);
        send_item(OP_START, 32'd11600, 1'b0, 1'b0);
        send_item(OP_POLL,  32'd11700, 1'b1, 1'b0);
        // The timestamp wraps between the start and the deadlines.
        send_item(OP_START, 32'hFFFF_F000, 1'b0, 1'b1);
        send_item(OP_POLL,  32'h0000_1000, 1'b0, 1'b0);
        send_item(OP_POLL,  32'h0000_1710, 1'b0, 1'b0);
        send_item(OP_POLL,  32'h0000_1AF7, 1'b0, 1'b0);
        send_item(OP_POLL,  32'h0000_1AF8, 1'b0, 1'b1);
        send_item(OP_POLL,  32'h0000_1B00, 1'b1, 1'b0);

        // An initial backoff above the cap falls back to the cap after one retry.
        configure(31'd10, 31'd5000, 31'd1000);
        send_item(OP_START, 32'd0,    1'b0, 1'b1);
        send_item(OP_POLL,  32'd10,   1'b0, 1'b0);
        send_item(OP_POLL,  32'd5010, 1'b0, 1'b0);
        send_item(OP_POLL,  32'd5020, 1'b0, 1'b0);
        send_item(OP_POLL,  32'd6020, 1'b0, 1'b0);

        configure(CONNECT_TIMEOUT_RST, BACKOFF_INITIAL_RST, BACKOFF_MAX_RST);
        run_traffic(150);

        tx_no_idle = 1'b1;
        configure(31'd40, 31'd5, 31'd200);
        run_traffic(200);
        tx_no_idle = 1'b0;

        rx_no_stall = 1'b1;
        configure(31'd0, 31'd0, 31'd0);
        run_traffic(80);
        rx_no_stall = 1'b0;

        configure(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        run_traffic(100);

        configure(31'd100, 31'd3000, 31'd1000);
        run_traffic(80);

        configure(31'd1, 31'd1, 31'h7FFF_FFFF);
        run_traffic(150);

        repeat (3)
        begin
            configure(31'($urandom_range(5000, 0)), 31'($urandom_range(2000, 0)),
                      31'($urandom_range(20000, 0)));
            run_traffic(50);
        end

        quiesce();
        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0t: results missing, expected %0d more, actual 0", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("link_reconnect_backoff_controller test passed");
        else
            $display("link_reconnect_backoff_controller test failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/lrbc_pkg.sv
rtl/core/lrbc_step.sv
rtl/core/link_reconnect_backoff_controller.sv
verif/tb.sv
